/* design/tspi_pkg.sv */
// ----------------------------------------------------------------------------
// tspi_pkg
// Shared types and constants of the two-sample pose interpolator.
// ----------------------------------------------------------------------------
package tspi_pkg;

  localparam int STEPS = 32;
  localparam int CNT_W = $clog2(STEPS);

  localparam logic [15:0] DEFAULT_UNITS = 16'd1000;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;
  localparam logic [1:0] AX_H = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_BASE,
    ST_OFFS,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

/* design/two_sample_pose_interpolator_core.sv */
// ----------------------------------------------------------------------------
// two_sample_pose_interpolator_core
// Keeps the two newest pose samples and interpolates a pose between them.
// ----------------------------------------------------------------------------
// usage:
//   a command beat is taken when start is high and busy is low. a push
//   (in_operation = 0) stores a sample, gives no result and leaves busy
//   low, so the next beat may follow at once.
//   an evaluate (in_operation = 1) gives one result beat, marked by out_valid
//   for exactly one cycle. without a valid segment the result comes the cycle
//   after the command. otherwise busy is high through three setup steps (span
//   and base on a 32x16 multiplier, then the offset), per axis a load step,
//   32 shift-add multiply steps, 32 restoring divide steps and a finish step,
//   all four axes on one shared 49-bit adder. out_valid rises as busy falls.
//   the receiver cannot stall: each result must be taken in its cycle.
//   cfg_wr_en writes render_units_per_tick at once; write it only while idle.
//   synchronous reset clears both samples and sets the register to 1000.
// ----------------------------------------------------------------------------
module two_sample_pose_interpolator_core
  import tspi_pkg::*;
#(
  parameter int HEADING_SCALE = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [31:0]        in_sample_tick,
  input  logic signed [31:0] in_sample_x,
  input  logic signed [31:0] in_sample_y,
  input  logic signed [31:0] in_sample_z,
  input  logic [7:0]         in_sample_heading,
  input  logic [47:0]        in_render_time,
  output logic               out_valid,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic signed [31:0] out_pose_z,
  output logic signed [17:0] out_pose_heading,
  output logic               out_at_rest
);

  localparam logic signed [32:0] HSCALE = 33'(HEADING_SCALE);

  state_t state_r, state_nxt;

  logic [15:0] units_r, units_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [31:0] old_tick_r, old_tick_nxt, new_tick_r, new_tick_nxt;
  logic [31:0] old_x_r, old_x_nxt, old_y_r, old_y_nxt, old_z_r, old_z_nxt;
  logic [31:0] new_x_r, new_x_nxt, new_y_r, new_y_nxt, new_z_r, new_z_nxt;
  logic [7:0]  old_h_r, old_h_nxt, new_h_r, new_h_nxt;

  logic [47:0] rt_r, rt_nxt;
  logic [47:0] span_r, span_nxt;
  logic [47:0] base_r, base_nxt;
  logic [47:0] off_r, off_nxt;
  logic [79:0] pd_r, pd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic signed [32:0] a_r, a_nxt;
  logic        neg_r, neg_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        at_rest_r, at_rest_nxt;
  logic [31:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [17:0] ph_r, ph_nxt;

  logic        accept;
  logic        no_segment;
  logic        replace;
  logic [31:0] mul_op;
  logic [47:0] mul_p;
  logic [48:0] alu_a, alu_b;
  logic        alu_cin;
  logic [49:0] alu_sum;
  logic [47:0] rt_diff;
  logic [7:0]  h_diff;
  logic signed [32:0] h_from, h_to, h_new;
  logic signed [32:0] ld_a, ld_b, ld_d;
  logic signed [32:0] fin_res;
  logic        step_last;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign step_last = (cnt_r == CNT_W'(STEPS - 1));

  assign no_segment = (count_r != 2'd2) || (new_tick_r <= old_tick_r) || (units_r == 16'd0);

  // shared 32x16 multiplier for span and segment base
  assign mul_op = (state_r == ST_SPAN) ? (new_tick_r - old_tick_r) : old_tick_r;
  assign mul_p  = 48'(mul_op) * 48'(units_r);

  assign rt_diff = rt_r - base_r;

  // heading endpoints, shortest way round
  assign h_diff = new_h_r - old_h_r;
  assign h_from = $signed({25'd0, old_h_r}) * HSCALE;
  assign h_to   = h_from + $signed({{25{h_diff[7]}}, h_diff}) * HSCALE;
  assign h_new  = $signed({25'd0, new_h_r}) * HSCALE;

  always_comb begin
    unique case (axis_r)
      AX_X: begin
        ld_a = $signed({old_x_r[31], old_x_r});
        ld_b = $signed({new_x_r[31], new_x_r});
      end
      AX_Y: begin
        ld_a = $signed({old_y_r[31], old_y_r});
        ld_b = $signed({new_y_r[31], new_y_r});
      end
      AX_Z: begin
        ld_a = $signed({old_z_r[31], old_z_r});
        ld_b = $signed({new_z_r[31], new_z_r});
      end
      AX_H: begin
        ld_a = h_from;
        ld_b = h_to;
      end
      default: begin
        ld_a = '0;
        ld_b = '0;
      end
    endcase
  end

  assign ld_d = (ld_b < ld_a) ? (ld_a - ld_b) : (ld_b - ld_a);

  // shared adder: shift-add multiply, then restoring divide
  always_comb begin
    if (state_r == ST_MUL) begin
      alu_a   = {1'b0, pd_r[79:32]};
      alu_b   = pd_r[0] ? {1'b0, off_r} : '0;
      alu_cin = 1'b0;
    end else begin
      alu_a   = {pd_r[79:32], pd_r[31]};
      alu_b   = ~{1'b0, span_r};
      alu_cin = 1'b1;
    end
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + 50'(alu_cin);

  assign fin_res = neg_r ? (a_r - $signed({1'b0, pd_r[31:0]}))
                         : (a_r + $signed({1'b0, pd_r[31:0]}));

  assign replace = (count_r != 2'd0) && (in_sample_tick == new_tick_r);

  always_comb begin
    state_nxt     = state_r;
    units_nxt     = cfg_wr_en ? cfg_wr_data : units_r;
    count_nxt     = count_r;
    old_tick_nxt  = old_tick_r;
    old_x_nxt     = old_x_r;
    old_y_nxt     = old_y_r;
    old_z_nxt     = old_z_r;
    old_h_nxt     = old_h_r;
    new_tick_nxt  = new_tick_r;
    new_x_nxt     = new_x_r;
    new_y_nxt     = new_y_r;
    new_z_nxt     = new_z_r;
    new_h_nxt     = new_h_r;
    rt_nxt        = rt_r;
    span_nxt      = span_r;
    base_nxt      = base_r;
    off_nxt       = off_r;
    pd_nxt        = pd_r;
    cnt_nxt       = cnt_r;
    axis_nxt      = axis_r;
    a_nxt         = a_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    at_rest_nxt   = at_rest_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    ph_nxt        = ph_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_PUSH) begin
            if (!replace) begin
              if (count_r != 2'd0) begin
                old_tick_nxt = new_tick_r;
                old_x_nxt    = new_x_r;
                old_y_nxt    = new_y_r;
                old_z_nxt    = new_z_r;
                old_h_nxt    = new_h_r;
              end
              if (count_r != 2'd2) begin
                count_nxt = count_r + 2'd1;
              end
            end
            new_tick_nxt = in_sample_tick;
            new_x_nxt    = in_sample_x;
            new_y_nxt    = in_sample_y;
            new_z_nxt    = in_sample_z;
            new_h_nxt    = in_sample_heading;
          end else if (no_segment) begin
            px_nxt        = new_x_r;
            py_nxt        = new_y_r;
            pz_nxt        = new_z_r;
            ph_nxt        = h_new[17:0];
            at_rest_nxt   = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            rt_nxt    = in_render_time;
            state_nxt = ST_SPAN;
          end
        end
      end
      ST_SPAN: begin
        span_nxt  = mul_p;
        state_nxt = ST_BASE;
      end
      ST_BASE: begin
        base_nxt  = mul_p;
        state_nxt = ST_OFFS;
      end
      ST_OFFS: begin
        if (rt_r < base_r) begin
          off_nxt = '0;
        end else if (rt_diff > span_r) begin
          off_nxt = span_r;
        end else begin
          off_nxt = rt_diff;
        end
        axis_nxt  = AX_X;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        a_nxt     = ld_a;
        neg_nxt   = (ld_b < ld_a);
        pd_nxt    = {48'd0, ld_d[31:0]};
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        pd_nxt  = {alu_sum[48:0], pd_r[31:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (step_last) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        pd_nxt  = {(alu_sum[49] ? alu_sum[47:0] : alu_a[47:0]), pd_r[30:0], alu_sum[49]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (step_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        unique case (axis_r)
          AX_X:    px_nxt = fin_res[31:0];
          AX_Y:    py_nxt = fin_res[31:0];
          AX_Z:    pz_nxt = fin_res[31:0];
          AX_H:    ph_nxt = fin_res[17:0];
          default: px_nxt = px_r;
        endcase
        if (axis_r == AX_H) begin
          at_rest_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sample store and register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_r    <= DEFAULT_UNITS;
      count_r    <= 2'd0;
      old_tick_r <= '0;
      old_x_r    <= '0;
      old_y_r    <= '0;
      old_z_r    <= '0;
      old_h_r    <= '0;
      new_tick_r <= '0;
      new_x_r    <= '0;
      new_y_r    <= '0;
      new_z_r    <= '0;
      new_h_r    <= '0;
    end else begin
      units_r    <= units_nxt;
      count_r    <= count_nxt;
      old_tick_r <= old_tick_nxt;
      old_x_r    <= old_x_nxt;
      old_y_r    <= old_y_nxt;
      old_z_r    <= old_z_nxt;
      old_h_r    <= old_h_nxt;
      new_tick_r <= new_tick_nxt;
      new_x_r    <= new_x_nxt;
      new_y_r    <= new_y_nxt;
      new_z_r    <= new_z_nxt;
      new_h_r    <= new_h_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rt_r      <= rt_nxt;
    span_r    <= span_nxt;
    base_r    <= base_nxt;
    off_r     <= off_nxt;
    pd_r      <= pd_nxt;
    cnt_r     <= cnt_nxt;
    axis_r    <= axis_nxt;
    a_r       <= a_nxt;
    neg_r     <= neg_nxt;
    at_rest_r <= at_rest_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    pz_r      <= pz_nxt;
    ph_r      <= ph_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pose_x       = px_r;
  assign out_pose_y       = py_r;
  assign out_pose_z       = pz_r;
  assign out_pose_heading = ph_r;
  assign out_at_rest      = at_rest_r;

`ifndef NO_ASSERTIONS
  a_valid_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result beat while sequencer busy");

  a_push_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_PUSH) |=> !out_valid_r)
    else $error("push produced a result beat");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("sample count out of range");

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (pd_r[79:32] < span_r))
    else $error("partial remainder not below span");

  a_off_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (off_r <= span_r))
    else $error("offset outside segment");
`endif

endmodule

/* tb/two_sample_pose_interpolator_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_sample_pose_interpolator_core_test
// Drives push and evaluate command beats through the start/busy handshake in
// random bursts. A built-in pose predictor works out each expected result, and
// a monitor checks every strobed result field by field. The run steps the
// units-per-tick register through its extremes and several other settings.
// ----------------------------------------------------------------------------
module two_sample_pose_interpolator_core_test;
  import tspi_pkg::*;

  localparam int HEAD_SCALE = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [47:0] RT_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic               op;
    logic [31:0]        tick;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         heading;
    logic [47:0]        rt;
  } pose_cmd_t;

  typedef struct {
    logic [31:0]        tick;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         heading;
  } pose_sample_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [17:0] heading;
    logic               at_rest;
  } pose_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [15:0]        cfg_wr_data = '0;
  logic               start = 1'b0;
  logic               in_operation = 1'b0;
  logic [31:0]        in_sample_tick = '0;
  logic signed [31:0] in_sample_x = '0;
  logic signed [31:0] in_sample_y = '0;
  logic signed [31:0] in_sample_z = '0;
  logic [7:0]         in_sample_heading = '0;
  logic [47:0]        in_render_time = '0;
  logic               busy;
  logic               out_valid;
  logic signed [31:0] out_pose_x;
  logic signed [31:0] out_pose_y;
  logic signed [31:0] out_pose_z;
  logic signed [17:0] out_pose_heading;
  logic               out_at_rest;

  pose_cmd_t    cmd_backlog[$];
  pose_t        pose_expected[$];
  pose_cmd_t    cmd_held;
  pose_t        pose_want;
  pose_sample_t older_smp = '{default: '0};
  pose_sample_t newer_smp = '{default: '0};
  int           held_samples = 0;
  logic [15:0]  units_now = DEFAULT_UNITS;
  int           burst_left = 1;
  int           gap_left = 0;
  int           error_count = 0;
  int           push_count = 0;
  int           eval_count = 0;
  int           moving_count = 0;
  int           rest_count = 0;
  int           setting_count = 1;
  int           cycle_count = 0;
  logic [31:0]  gen_older = '0;
  logic [31:0]  gen_newer = '0;
  int           gen_count = 0;

  two_sample_pose_interpolator_core #(
    .HEADING_SCALE(HEAD_SCALE)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_sample_tick   (in_sample_tick),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .in_sample_z      (in_sample_z),
    .in_sample_heading(in_sample_heading),
    .in_render_time   (in_render_time),
    .out_valid        (out_valid),
    .out_pose_x       (out_pose_x),
    .out_pose_y       (out_pose_y),
    .out_pose_z       (out_pose_z),
    .out_pose_heading (out_pose_heading),
    .out_at_rest      (out_at_rest)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // a + (b - a) * off / span, exact product, quotient truncated toward zero
  function automatic logic [63:0] lerp_axis(longint a, longint b, longint off, longint span);
    logic [127:0] prod;
    logic [63:0]  mag;
    logic [63:0]  q;
    mag = (b < a) ? 64'(a - b) : 64'(b - a);
    prod = {64'd0, mag} * {64'd0, 64'(off)};
    q = 64'(prod / {64'd0, 64'(span)});
    return (b < a) ? 64'(a) - q : 64'(a) + q;
  endfunction

  function automatic pose_t predict_pose(logic [47:0] rt);
    pose_t      p;
    longint     units;
    longint     span;
    longint     off;
    longint     hfrom;
    longint     hto;
    logic [7:0] dh;
    units = longint'({48'd0, units_now});
    span = 0;
    if (held_samples >= 2) begin
      span = (longint'({32'd0, newer_smp.tick}) - longint'({32'd0, older_smp.tick})) * units;
    end
    if (span <= 0) begin
      p.x = newer_smp.x;
      p.y = newer_smp.y;
      p.z = newer_smp.z;
      p.heading = 18'(int'(newer_smp.heading) * HEAD_SCALE);
      p.at_rest = 1'b1;
    end else begin
      off = longint'({16'd0, rt}) - longint'({32'd0, older_smp.tick}) * units;
      if (off < 0) off = 0;
      if (off > span) off = span;
      dh = newer_smp.heading - older_smp.heading;
      hfrom = longint'(int'(older_smp.heading)) * HEAD_SCALE;
      hto = hfrom + longint'($signed(dh)) * HEAD_SCALE;
      p.x = 32'(lerp_axis(older_smp.x, newer_smp.x, off, span));
      p.y = 32'(lerp_axis(older_smp.y, newer_smp.y, off, span));
      p.z = 32'(lerp_axis(older_smp.z, newer_smp.z, off, span));
      p.heading = 18'(lerp_axis(hfrom, hto, off, span));
      p.at_rest = 1'b0;
    end
    return p;
  endfunction

  task automatic flag_pose_error(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // driver: bursts of command beats with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cmd_held.op == OP_PUSH) begin
          if (!(held_samples != 0 && cmd_held.tick == newer_smp.tick)) begin
            if (held_samples != 0) older_smp = newer_smp;
            if (held_samples < 2) held_samples++;
          end
          newer_smp = '{cmd_held.tick, cmd_held.x, cmd_held.y, cmd_held.z, cmd_held.heading};
          push_count++;
        end else begin
          pose_expected.push_back(predict_pose(cmd_held.rt));
          eval_count++;
        end
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          cmd_held = cmd_backlog.pop_front();
          in_operation <= cmd_held.op;
          in_sample_tick <= cmd_held.tick;
          in_sample_x <= cmd_held.x;
          in_sample_y <= cmd_held.y;
          in_sample_z <= cmd_held.z;
          in_sample_heading <= cmd_held.heading;
          in_render_time <= cmd_held.rt;
          start <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 5))
              0, 1: gap_left = 0;
              2: gap_left = $urandom_range(3, 40);
              default: gap_left = $urandom_range(1, 2);
            endcase
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each strobed result beat against the oldest expected pose
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pose_expected.size() == 0) begin
        flag_pose_error("result beat with no evaluate pending", 64'(out_pose_x), 64'd0);
      end else begin
        pose_want = pose_expected.pop_front();
        if (out_pose_x !== pose_want.x)
          flag_pose_error("pose_x", 64'(out_pose_x), 64'(pose_want.x));
        if (out_pose_y !== pose_want.y)
          flag_pose_error("pose_y", 64'(out_pose_y), 64'(pose_want.y));
        if (out_pose_z !== pose_want.z)
          flag_pose_error("pose_z", 64'(out_pose_z), 64'(pose_want.z));
        if (out_pose_heading !== pose_want.heading)
          flag_pose_error("pose_heading", 64'(out_pose_heading), 64'(pose_want.heading));
        if (out_at_rest !== pose_want.at_rest)
          flag_pose_error("at_rest", 64'(out_at_rest), 64'(pose_want.at_rest));
        if (pose_want.at_rest) rest_count++;
        else moving_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("two_sample_pose_interpolator_core_test NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_push(logic [31:0] tick, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [7:0] h);
    pose_cmd_t c;
    c.op = OP_PUSH;
    c.tick = tick;
    c.x = x;
    c.y = y;
    c.z = z;
    c.heading = h;
    c.rt = 48'({$urandom(), $urandom()});
    cmd_backlog.push_back(c);
    if (!(gen_count != 0 && tick == gen_newer)) begin
      if (gen_count != 0) gen_older = gen_newer;
      if (gen_count < 2) gen_count++;
      gen_newer = tick;
    end
  endtask

  task automatic queue_eval(logic [47:0] rt);
    pose_cmd_t c;
    c.op = OP_EVAL;
    c.tick = $urandom();
    c.x = $urandom();
    c.y = $urandom();
    c.z = $urandom();
    c.heading = 8'($urandom());
    c.rt = rt;
    cmd_backlog.push_back(c);
  endtask

  // mostly advancing ticks with render times around the live segment
  task automatic queue_random(int n);
    logic [31:0] tick;
    longint      units;
    longint      base;
    longint      span;
    longint      rt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0: tick = gen_newer;
          1: tick = $urandom();
          2: tick = gen_newer - $urandom_range(1, 10);
          default: tick = (gen_count == 0) ? $urandom_range(0, 1000) :
                                             gen_newer + $urandom_range(1, 40);
        endcase
        queue_push(tick, pick_coord(), pick_coord(), pick_coord(), 8'($urandom_range(0, 255)));
      end else begin
        units = longint'({48'd0, units_now});
        base = longint'({32'd0, gen_older}) * units;
        span = (longint'({32'd0, gen_newer}) - longint'({32'd0, gen_older})) * units;
        case ($urandom_range(0, 9))
          0, 1: rt = longint'({16'd0, 48'({$urandom(), $urandom()})});
          2: rt = base;
          3: rt = base + span;
          default: begin
            if (gen_count >= 2 && span > 0)
              rt = base - span / 10 + (span * longint'($urandom_range(0, 1200))) / 1000;
            else
              rt = base + longint'($urandom_range(0, 2000)) - 1000;
          end
        endcase
        if (rt < 0) rt = 0;
        if (rt > longint'({16'd0, RT_MAX})) rt = longint'({16'd0, RT_MAX});
        queue_eval(48'(rt));
      end
    end
  endtask

  task automatic settle();
    while (cmd_backlog.size() != 0 || start || pose_expected.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_units(logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    units_now = v;
    setting_count++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty, single sample, replace, clamping, heading wrap, backward tick
    queue_eval(48'd0);
    queue_push(32'd10, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 8'hFF);
    queue_eval(48'd10000);
    queue_push(32'd10, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFE);
    queue_eval(48'd10000);
    queue_push(32'd20, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 8'h01);
    queue_eval(48'd0);
    queue_eval(48'd15000);
    queue_eval(48'd15333);
    queue_eval(RT_MAX);
    queue_push(32'd30, 32'd0, 32'd0, 32'd0, 8'h81);
    queue_eval(48'd25000);
    queue_push(32'd25, 32'h1234_5678, 32'hDEAD_BEEF, 32'h0F0F_0F0F, 8'h40);
    queue_eval(48'd25000);
    queue_push(32'd25, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001, 8'h00);
    queue_push(32'd26, 32'h7FFF_FFFE, 32'hFFFF_FFFE, 32'h0000_0002, 8'h80);
    queue_eval(48'd25500);
    queue_eval(48'd26000);
    settle();

    // widest segment at the largest register value
    write_units(16'hFFFF);
    queue_push(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 8'h00);
    queue_push(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 8'h7F);
    queue_eval(RT_MAX);
    queue_eval(48'h7FFF_8000_0000);
    queue_eval(48'd0);
    queue_random(160);
    settle();

    write_units(16'd1);
    queue_random(165);
    settle();

    write_units(16'd0);
    queue_random(70);
    settle();

    write_units(16'($urandom_range(2, 65534)));
    queue_random(165);
    settle();

    write_units(DEFAULT_UNITS);
    queue_random(165);
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d pushes and %0d evaluates (%0d interpolated, %0d at rest)",
             push_count, eval_count, moving_count, rest_count);
    $display("over %0d register settings, %0d mismatches", setting_count, error_count);
    if (error_count == 0) begin
      $display("two_sample_pose_interpolator_core_test OK");
    end else begin
      $display("two_sample_pose_interpolator_core_test NOT OK");
    end
    $finish;
  end

endmodule
